FILE: hw/rtl/gbfs_pkg.sv
// Shared types and codes for the graph breadth-first search block.
`timescale 1ns / 1ps
package gbfs_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_EMIT   = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_ADD    = 2'd2,
        ACT_SEARCH = 2'd3
    } t_act;

    typedef struct packed {
        t_act    act;
        t_status status;
    } t_check;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RA,
        S_ADD_WA,
        S_ADD_RB,
        S_ADD_WB,
        S_EMIT,
        S_POP,
        S_HEAD,
        S_LINK,
        S_EDGE,
        S_VEMIT
    } t_state;

    localparam int VERTEX_W  = 6;
    localparam int VCOUNT_W  = 7;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

endpackage

FILE: hw/rtl/gbfs_item_if.sv
// Input item channel: mode and two vertex indices.
`timescale 1ns / 1ps
interface gbfs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [5:0] first_vertex;
    logic [5:0] second_vertex;

    modport source (output valid, output mode, output first_vertex, output second_vertex,
                    input ready);
    modport sink   (input valid, input mode, input first_vertex, input second_vertex,
                    output ready);
endinterface

FILE: hw/rtl/gbfs_result_if.sv
// Result channel: visited vertex, last flag and status.
`timescale 1ns / 1ps
interface gbfs_result_if;
    logic       valid;
    logic       ready;
    logic [5:0] visited_vertex;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output visited_vertex, output last, output status,
                    input ready);
    modport sink   (input valid, input visited_vertex, input last, input status,
                    output ready);
endinterface

FILE: hw/rtl/gbfs_cfg_if.sv
// Configuration write channel carrying the vertex count.
`timescale 1ns / 1ps
interface gbfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] vertex_count;

    modport source (output valid, output vertex_count, input ready);
    modport sink   (input valid, input vertex_count, output ready);
endinterface

FILE: hw/rtl/gbfs_check.sv
// Item decode: range and edge store capacity checks, chooses the action.
`timescale 1ns / 1ps
module gbfs_check #(
    parameter int VERTICES   = 64,
    parameter int EDGE_SLOTS = 512,
    parameter int LW         = 10
) (
    input  logic [gbfs_pkg::VCOUNT_W-1:0] i_vertex_count,
    input  gbfs_pkg::t_mode               i_mode,
    input  logic [gbfs_pkg::VERTEX_W-1:0] i_first_vertex,
    input  logic [gbfs_pkg::VERTEX_W-1:0] i_second_vertex,
    input  logic [LW-1:0]                 i_used,
    output gbfs_pkg::t_check              o_check
);
    import gbfs_pkg::*;

    localparam logic [VCOUNT_W-1:0] VMAX  = VCOUNT_W'(VERTICES);
    localparam logic [LW:0]         SLOTS = (LW+1)'(EDGE_SLOTS);

    logic [VCOUNT_W-1:0] n_active;
    logic                bad_a;
    logic                bad_b;
    logic                full;

    assign n_active = (i_vertex_count > VMAX) ? VMAX : i_vertex_count;
    assign bad_a    = {1'b0, i_first_vertex} >= n_active;
    assign bad_b    = {1'b0, i_second_vertex} >= n_active;
    assign full     = ({1'b0, i_used} + (LW+1)'(2)) > SLOTS;

    always_comb begin
        o_check.act    = ACT_EMIT;
        o_check.status = ST_OK;
        unique case (i_mode)
            MODE_CLEAR: begin
                o_check.act = ACT_CLEAR;
            end
            MODE_ADD: begin
                if (bad_a || bad_b) begin
                    o_check.status = ST_RANGE;
                end else if (full) begin
                    o_check.status = ST_FULL;
                end else begin
                    o_check.act = ACT_ADD;
                end
            end
            MODE_SEARCH: begin
                if (bad_a) begin
                    o_check.status = ST_RANGE;
                end else begin
                    o_check.act = ACT_SEARCH;
                end
            end
            default: begin
                o_check.act = ACT_EMIT;
            end
        endcase
    end

endmodule

FILE: hw/rtl/graph_breadth_first_search.sv
// Top level: adjacency-list graph store and breadth-first search sequencer.
//
//  channel   | dir | beat contents
//  ----------+-----+----------------------------------------------
//  i_item    | in  | mode, first_vertex, second_vertex
//  o_result  | out | visited_vertex, last, status
//  i_cfg     | in  | vertex_count (always ready)
//
// Clear and rejected items go straight to the result beat. Add edge reads and
// writes the list head of each end. Search pops, reads the head and walks the
// edge list of each visited vertex, one edge memory read per cycle.
// Reset empties the graph at once through per-vertex list valid bits.
// A stalled result beat holds the sequencer at its next result; input is
// taken again once the current item has queued its final beat.
`timescale 1ns / 1ps
module graph_breadth_first_search #(
    parameter int VERTICES   = 64,
    parameter int EDGE_SLOTS = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gbfs_item_if.sink    i_item,
    gbfs_result_if.source o_result,
    gbfs_cfg_if.sink     i_cfg
);
    import gbfs_pkg::*;

    localparam int VW  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int QCW = $clog2(VERTICES + 1);
    localparam int LW  = $clog2(EDGE_SLOTS + 1);
    localparam int SW  = $clog2(EDGE_SLOTS);

    t_state              r_state, n_state;
    logic [VCOUNT_W-1:0] r_vcount;
    logic [VERTICES-1:0] r_hvalid, n_hvalid;
    logic [VERTICES-1:0] r_visited, n_visited;
    logic [LW-1:0]       r_used, n_used;
    logic [QCW-1:0]      r_front, n_front;
    logic [QCW-1:0]      r_rear, n_rear;
    logic [VW-1:0]       r_a, n_a;
    logic [VW-1:0]       r_b, n_b;
    logic [VW-1:0]       r_cur, n_cur;
    t_status             r_status, n_status;

    logic                r_ovalid;
    logic [VERTEX_W-1:0] r_overtex;
    logic                r_olast;
    t_status             r_ostatus;

    logic [LW-1:0]       m_head [VERTICES];
    logic [VW-1:0]       m_edge_nb [EDGE_SLOTS];
    logic [LW-1:0]       m_edge_nx [EDGE_SLOTS];
    logic [VW-1:0]       m_queue [VERTICES];

    logic [LW-1:0]       r_head_rd;
    logic                r_head_vld;
    logic [VW-1:0]       r_enb;
    logic [LW-1:0]       r_enx;
    logic [VW-1:0]       r_q_rd;

    logic [VW-1:0]       head_raddr;
    logic                head_we;
    logic [VW-1:0]       head_waddr;
    logic [LW-1:0]       head_wdata;
    logic                edge_we;
    logic [SW-1:0]       edge_waddr;
    logic [VW-1:0]       edge_wnb;
    logic [LW-1:0]       edge_wnx;
    logic [SW-1:0]       edge_raddr;
    logic                q_we;
    logic [VW-1:0]       q_waddr;
    logic [VW-1:0]       q_wdata;

    logic                out_free;
    logic                out_load;
    logic [VERTEX_W-1:0] out_vertex;
    logic                out_last;
    t_status             out_status;

    logic                item_acc;
    logic [VW-1:0]       item_a;
    logic [VW-1:0]       item_b;
    t_check              chk;
    logic [LW-1:0]       head_eff;
    logic [LW-1:0]       head_m1;
    logic [LW-1:0]       nx_m1;
    logic                enq;

    gbfs_check #(
        .VERTICES   (VERTICES),
        .EDGE_SLOTS (EDGE_SLOTS),
        .LW         (LW)
    ) u_check (
        .i_vertex_count  (r_vcount),
        .i_mode          (t_mode'(i_item.mode)),
        .i_first_vertex  (i_item.first_vertex),
        .i_second_vertex (i_item.second_vertex),
        .i_used          (r_used),
        .o_check         (chk)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign item_acc     = i_item.valid && i_item.ready;
    assign item_a       = i_item.first_vertex[VW-1:0];
    assign item_b       = i_item.second_vertex[VW-1:0];

    assign o_result.valid          = r_ovalid;
    assign o_result.visited_vertex = r_overtex;
    assign o_result.last           = r_olast;
    assign o_result.status         = r_ostatus;
    assign out_free = !r_ovalid || o_result.ready;

    assign head_eff = r_head_vld ? r_head_rd : '0;
    assign head_m1  = head_eff - LW'(1);
    assign nx_m1    = r_enx - LW'(1);
    assign enq      = (QCW'(r_enb) < QCW'(VERTICES)) && !r_visited[r_enb]
                      && (r_rear < QCW'(VERTICES));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (item_acc) begin
                    unique case (chk.act)
                        ACT_ADD:    n_state = S_ADD_RA;
                        ACT_SEARCH: n_state = S_POP;
                        default:    n_state = S_EMIT;
                    endcase
                end
            end
            S_ADD_RA: n_state = S_ADD_WA;
            S_ADD_WA: n_state = S_ADD_RB;
            S_ADD_RB: n_state = S_ADD_WB;
            S_ADD_WB: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_POP:  n_state = S_HEAD;
            S_HEAD: n_state = S_LINK;
            S_LINK: begin
                n_state = (head_eff == '0) ? S_VEMIT : S_EDGE;
            end
            S_EDGE: begin
                if (r_enx == '0) begin
                    n_state = S_VEMIT;
                end
            end
            S_VEMIT: begin
                if (out_free) begin
                    n_state = (r_front >= r_rear) ? S_IDLE : S_POP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_used     = r_used;
        n_hvalid   = r_hvalid;
        n_visited  = r_visited;
        n_front    = r_front;
        n_rear     = r_rear;
        n_a        = r_a;
        n_b        = r_b;
        n_cur      = r_cur;
        n_status   = r_status;
        head_raddr = r_a;
        head_we    = 1'b0;
        head_waddr = r_a;
        head_wdata = r_used + LW'(1);
        edge_we    = 1'b0;
        edge_waddr = r_used[SW-1:0];
        edge_wnb   = r_b;
        edge_wnx   = head_eff;
        edge_raddr = nx_m1[SW-1:0];
        q_we       = 1'b0;
        q_waddr    = r_rear[VW-1:0];
        q_wdata    = r_enb;
        out_load   = 1'b0;
        out_vertex = '0;
        out_last   = 1'b1;
        out_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (item_acc) begin
                    n_a      = item_a;
                    n_b      = item_b;
                    n_status = chk.status;
                    unique case (chk.act)
                        ACT_CLEAR: begin
                            n_hvalid = '0;
                            n_used   = '0;
                        end
                        ACT_SEARCH: begin
                            n_visited         = '0;
                            n_visited[item_a] = 1'b1;
                            q_we              = 1'b1;
                            q_waddr           = '0;
                            q_wdata           = item_a;
                            n_front           = '0;
                            n_rear            = QCW'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_RA: head_raddr = r_a;
            S_ADD_WA: begin
                edge_we         = 1'b1;
                edge_wnb        = r_b;
                head_we         = 1'b1;
                head_waddr      = r_a;
                n_hvalid[r_a]   = 1'b1;
                n_used          = r_used + LW'(1);
            end
            S_ADD_RB: head_raddr = r_b;
            S_ADD_WB: begin
                edge_we         = 1'b1;
                edge_wnb        = r_a;
                head_we         = 1'b1;
                head_waddr      = r_b;
                n_hvalid[r_b]   = 1'b1;
                n_used          = r_used + LW'(1);
            end
            S_EMIT: out_load = out_free;
            S_POP:  n_front = r_front + QCW'(1);
            S_HEAD: begin
                n_cur      = r_q_rd;
                head_raddr = r_q_rd;
            end
            S_LINK: edge_raddr = head_m1[SW-1:0];
            S_EDGE: begin
                if (enq) begin
                    n_visited[r_enb] = 1'b1;
                    q_we             = 1'b1;
                    n_rear           = r_rear + QCW'(1);
                end
            end
            S_VEMIT: begin
                out_load   = out_free;
                out_vertex = VERTEX_W'(r_cur);
                out_last   = (r_front >= r_rear);
                out_status = ST_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= VCOUNT_RESET;
            r_hvalid  <= '0;
            r_visited <= '0;
            r_used    <= '0;
            r_front   <= '0;
            r_rear    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hvalid  <= n_hvalid;
            r_visited <= n_visited;
            r_used    <= n_used;
            r_front   <= n_front;
            r_rear    <= n_rear;
            if (i_cfg.valid && i_cfg.ready) begin
                r_vcount <= i_cfg.vertex_count;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_cur    <= n_cur;
        r_status <= n_status;
        if (out_load) begin
            r_overtex <= out_vertex;
            r_olast   <= out_last;
            r_ostatus <= out_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            m_head[head_waddr] <= head_wdata;
        end
        r_head_rd  <= m_head[head_raddr];
        r_head_vld <= r_hvalid[head_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            m_edge_nb[edge_waddr] <= edge_wnb;
            m_edge_nx[edge_waddr] <= edge_wnx;
        end
        r_enb <= m_edge_nb[edge_raddr];
        r_enx <= m_edge_nx[edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            m_queue[q_waddr] <= q_wdata;
        end
        r_q_rd <= m_queue[r_front[VW-1:0]];
    end

    a_front_le_rear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= r_rear)
        else $error("queue front passed rear");

    a_rear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rear <= QCW'(VERTICES))
        else $error("queue rear beyond vertex count");

    a_edge_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_we |-> (r_used < LW'(EDGE_SLOTS)))
        else $error("edge slot written past the store");

    a_marks_match_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP || r_state == S_HEAD || r_state == S_LINK
         || r_state == S_EDGE || r_state == S_VEMIT)
        |-> ($countones(r_visited) == int'(r_rear)))
        else $error("visited marks disagree with queued vertices");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VEMIT && out_load && out_last) |=> (r_state == S_IDLE))
        else $error("search continued after final beat");

endmodule

FILE: dv/graph_breadth_first_search_tb.sv
// Self-checking bench for the graph breadth-first search block: directed table, then random traffic.
`timescale 1ns / 1ps
module graph_breadth_first_search_tb;
    import gbfs_pkg::*;

    localparam int NUM_V     = 64;
    localparam int NUM_SLOTS = 512;
    localparam int GAP_MAX   = 6;
    localparam int FILL_VCOUNT = 32;
    localparam int PHASE_ITEMS = 35;
    localparam int PHASE_VCOUNT [6] = '{3, 64, 1, 100, 17, 64};

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                last;
        t_status             status;
    } t_visit;

    typedef struct packed {
        t_row_kind           kind;
        t_mode               mode;
        logic [VERTEX_W-1:0] first_v;
        logic [VERTEX_W-1:0] second_v;
        logic [VCOUNT_W-1:0] vcount;
        logic                typed;
        t_visit              want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    gbfs_item_if   item_bus ();
    gbfs_result_if result_bus ();
    gbfs_cfg_if    cfg_bus ();

    graph_breadth_first_search #(
        .VERTICES   (NUM_V),
        .EDGE_SLOTS (NUM_SLOTS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    logic [VCOUNT_W-1:0] vcount_cfg;
    logic [9:0]          head_link [NUM_V];
    logic [VERTEX_W-1:0] slot_nbr [NUM_SLOTS];
    logic [9:0]          slot_next [NUM_SLOTS];
    int                  slots_used;

    t_visit visit_q [$];
    t_visit bfs_out [$];
    t_visit got_want;
    t_row   directed_plan [25];
    int     fail_count;
    bit     send_idle_en;
    bit     recv_stall_en;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_visit visit(int v, bit last, t_status st);
        t_visit r;
        r.vertex = VERTEX_W'(v);
        r.last   = last;
        r.status = st;
        return r;
    endfunction

    function automatic int active_count();
        return (vcount_cfg > NUM_V) ? NUM_V : int'(vcount_cfg);
    endfunction

    function automatic void push_link(int owner, int nbr);
        slot_nbr[slots_used]  = VERTEX_W'(nbr);
        slot_next[slots_used] = head_link[owner];
        head_link[owner]      = 10'(slots_used + 1);
        slots_used++;
    endfunction

    function automatic void predict_item(t_mode mode, int a, int b);
        int n;
        int front;
        int rear;
        int cur;
        int link;
        int order [NUM_V];
        bit seen [NUM_V];
        n = active_count();
        bfs_out.delete();
        case (mode)
            MODE_CLEAR: begin
                foreach (head_link[i]) head_link[i] = '0;
                slots_used = 0;
                bfs_out.push_back(visit(0, 1'b1, ST_OK));
            end
            MODE_ADD: begin
                if (a >= n || b >= n) begin
                    bfs_out.push_back(visit(0, 1'b1, ST_RANGE));
                end else if (NUM_SLOTS - slots_used < 2) begin
                    bfs_out.push_back(visit(0, 1'b1, ST_FULL));
                end else begin
                    push_link(a, b);
                    push_link(b, a);
                    bfs_out.push_back(visit(0, 1'b1, ST_OK));
                end
            end
            MODE_SEARCH: begin
                if (a >= n) begin
                    bfs_out.push_back(visit(0, 1'b1, ST_RANGE));
                end else begin
                    foreach (seen[i]) seen[i] = 1'b0;
                    front    = 0;
                    rear     = 1;
                    order[0] = a;
                    seen[a]  = 1'b1;
                    while (front < rear) begin
                        cur = order[front];
                        front++;
                        link = head_link[cur];
                        while (link != 0) begin
                            if (!seen[slot_nbr[link-1]]) begin
                                seen[slot_nbr[link-1]] = 1'b1;
                                order[rear] = slot_nbr[link-1];
                                rear++;
                            end
                            link = slot_next[link-1];
                        end
                        bfs_out.push_back(visit(cur, front >= rear, ST_OK));
                    end
                end
            end
            default: begin
                bfs_out.push_back(visit(0, 1'b1, ST_OK));
            end
        endcase
    endfunction

    task automatic send_item(t_mode mode, int a, int b, bit typed, t_visit want);
        int gap;
        if (send_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, GAP_MAX);
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.mode          <= mode;
        item_bus.first_vertex  <= VERTEX_W'(a);
        item_bus.second_vertex <= VERTEX_W'(b);
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        predict_item(mode, a, b);
        if (typed) begin
            visit_q.push_back(want);
        end else begin
            foreach (bfs_out[i]) visit_q.push_back(bfs_out[i]);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        while (visit_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_vcount(int v);
        wait_idle();
        cfg_bus.valid        <= 1'b1;
        cfg_bus.vertex_count <= VCOUNT_W'(v);
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        vcount_cfg = VCOUNT_W'(v);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic random_item();
        int    n;
        int    r;
        int    a;
        int    b;
        t_mode mode;
        n = active_count();
        r = $urandom_range(0, 99);
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        if (r < 55) begin
            mode = MODE_ADD;
        end else if (r < 80) begin
            mode = MODE_SEARCH;
            b    = $urandom_range(0, NUM_V - 1);
        end else if (r < 85) begin
            mode = MODE_CLEAR;
            a    = $urandom_range(0, NUM_V - 1);
            b    = $urandom_range(0, NUM_V - 1);
        end else if (r < 93) begin
            mode = $urandom_range(0, 1) ? MODE_ADD : MODE_SEARCH;
            if (n < NUM_V) begin
                if ($urandom_range(0, 1)) a = $urandom_range(n, NUM_V - 1);
                else b = $urandom_range(n, NUM_V - 1);
            end
        end else begin
            mode = MODE_SPARE;
            a    = $urandom_range(0, NUM_V - 1);
            b    = $urandom_range(0, NUM_V - 1);
        end
        send_item(mode, a, b, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (visit_q.size() == 0) begin
                $error("unexpected result beat: visited_vertex %0d last %0b status %0d",
                       result_bus.visited_vertex, result_bus.last, result_bus.status);
                fail_count++;
            end else begin
                got_want = visit_q.pop_front();
                if (result_bus.visited_vertex !== got_want.vertex) begin
                    $error("visited_vertex: expected %0d, actual %0d",
                           got_want.vertex, result_bus.visited_vertex);
                    fail_count++;
                end
                if (result_bus.last !== got_want.last) begin
                    $error("last: expected %0b, actual %0b", got_want.last, result_bus.last);
                    fail_count++;
                end
                if (result_bus.status !== got_want.status) begin
                    $error("status: expected %0d, actual %0d",
                           got_want.status, result_bus.status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int gap;
        result_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (recv_stall_en && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, GAP_MAX);
                result_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            result_bus.ready <= 1'b1;
        end
    end

    initial begin
        int a;
        int b;
        int adds;
        int phase;
        i_rst_n                = 1'b0;
        item_bus.valid         = 1'b0;
        item_bus.mode          = MODE_CLEAR;
        item_bus.first_vertex  = '0;
        item_bus.second_vertex = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.vertex_count   = VCOUNT_RESET;
        fail_count             = 0;
        send_idle_en           = 1'b1;
        recv_stall_en          = 1'b1;
        vcount_cfg             = VCOUNT_RESET;
        slots_used             = 0;
        foreach (head_link[i]) head_link[i] = '0;

        directed_plan = '{
            '{ROW_ITEM, MODE_SEARCH, 6'd0,  6'd0,  7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_ITEM, MODE_SEARCH, 6'd63, 6'd63, 7'd0,   1'b1, '{6'd63, 1'b1, ST_OK}},
            '{ROW_ITEM, MODE_CLEAR,  6'd63, 6'd63, 7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_ITEM, MODE_SPARE,  6'd63, 6'd63, 7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_ITEM, MODE_ADD,    6'd0,  6'd63, 7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_ITEM, MODE_ADD,    6'd63, 6'd63, 7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_ITEM, MODE_ADD,    6'd5,  6'd0,  7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_ITEM, MODE_ADD,    6'd5,  6'd42, 7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_ITEM, MODE_SEARCH, 6'd0,  6'd0,  7'd0,   1'b0, '0},
            '{ROW_ITEM, MODE_SEARCH, 6'd63, 6'd21, 7'd0,   1'b0, '0},
            '{ROW_ITEM, MODE_SEARCH, 6'd42, 6'd0,  7'd0,   1'b0, '0},
            '{ROW_CFG,  MODE_CLEAR,  6'd0,  6'd0,  7'd8,   1'b0, '0},
            '{ROW_ITEM, MODE_ADD,    6'd8,  6'd0,  7'd0,   1'b1, '{6'd0,  1'b1, ST_RANGE}},
            '{ROW_ITEM, MODE_ADD,    6'd0,  6'd8,  7'd0,   1'b1, '{6'd0,  1'b1, ST_RANGE}},
            '{ROW_ITEM, MODE_SEARCH, 6'd8,  6'd0,  7'd0,   1'b1, '{6'd0,  1'b1, ST_RANGE}},
            '{ROW_ITEM, MODE_SEARCH, 6'd7,  6'd0,  7'd0,   1'b1, '{6'd7,  1'b1, ST_OK}},
            '{ROW_ITEM, MODE_SEARCH, 6'd5,  6'd0,  7'd0,   1'b0, '0},
            '{ROW_ITEM, MODE_ADD,    6'd7,  6'd5,  7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_CFG,  MODE_CLEAR,  6'd0,  6'd0,  7'd0,   1'b0, '0},
            '{ROW_ITEM, MODE_SEARCH, 6'd0,  6'd0,  7'd0,   1'b1, '{6'd0,  1'b1, ST_RANGE}},
            '{ROW_ITEM, MODE_ADD,    6'd0,  6'd0,  7'd0,   1'b1, '{6'd0,  1'b1, ST_RANGE}},
            '{ROW_ITEM, MODE_CLEAR,  6'd0,  6'd0,  7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_CFG,  MODE_CLEAR,  6'd0,  6'd0,  7'd127, 1'b0, '0},
            '{ROW_ITEM, MODE_ADD,    6'd42, 6'd21, 7'd0,   1'b1, '{6'd0,  1'b1, ST_OK}},
            '{ROW_ITEM, MODE_SEARCH, 6'd21, 6'd42, 7'd0,   1'b0, '0}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                write_vcount(directed_plan[i].vcount);
            end else begin
                send_item(directed_plan[i].mode, directed_plan[i].first_v,
                          directed_plan[i].second_v, directed_plan[i].typed,
                          directed_plan[i].want);
            end
        end

        // fill the edge store to capacity, then probe the full and range cases
        write_vcount(FILL_VCOUNT);
        send_item(MODE_CLEAR, 0, 0, 1'b0, '0);
        adds = 0;
        while (slots_used < NUM_SLOTS) begin
            a = $urandom_range(0, FILL_VCOUNT - 1);
            b = $urandom_range(0, FILL_VCOUNT - 1);
            if ($urandom_range(0, 7) == 0) a = $urandom_range(FILL_VCOUNT, NUM_V - 1);
            send_item(MODE_ADD, a, b, 1'b0, '0);
            adds++;
            if (adds % 48 == 0) begin
                send_item(MODE_SEARCH, $urandom_range(0, FILL_VCOUNT - 1),
                          $urandom_range(0, NUM_V - 1), 1'b0, '0);
            end
            if (adds == 100) wait_idle();
        end
        send_item(MODE_ADD, 1, 2, 1'b0, '0);
        send_item(MODE_ADD, FILL_VCOUNT - 1, FILL_VCOUNT - 1, 1'b0, '0);
        send_item(MODE_ADD, NUM_V - 1, 1, 1'b0, '0);
        send_item(MODE_SEARCH, 0, 0, 1'b0, '0);
        send_item(MODE_SEARCH, FILL_VCOUNT - 1, NUM_V - 1, 1'b0, '0);
        send_item(MODE_SEARCH, $urandom_range(0, FILL_VCOUNT - 1), 0, 1'b0, '0);
        send_item(MODE_CLEAR, 0, 0, 1'b0, '0);

        for (phase = 0; phase < 6; phase++) begin
            write_vcount(PHASE_VCOUNT[phase]);
            send_idle_en  = (phase != 3 && phase != 5);
            recv_stall_en = (phase != 3 && phase != 5);
            repeat (PHASE_ITEMS) random_item();
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: graph_breadth_first_search.f
hw/rtl/gbfs_pkg.sv
hw/rtl/gbfs_item_if.sv
hw/rtl/gbfs_result_if.sv
hw/rtl/gbfs_cfg_if.sv
hw/rtl/gbfs_check.sv
hw/rtl/graph_breadth_first_search.sv
dv/graph_breadth_first_search_tb.sv
